// ===== rtl/rcfm_pkg.sv =====
// shared types, constants and codes for the relay contact fault monitor
package rcfm_pkg;

  localparam int RELAY_COUNT = 16;
  localparam int TIMER_WIDTH = 16;
  localparam int LANE_W      = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
  localparam int INDEX_W     = 5;
  localparam int COIL_W      = 16;
  localparam int TYPE_W      = 16;
  localparam int ACTIVE_W    = 5;
  localparam int SETTLE_W    = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(100);

  typedef enum logic [1:0] {
    OP_SET_COIL     = 2'd0,
    OP_TICK         = 2'd1,
    OP_READ_CONTACT = 2'd2,
    OP_READ_FAULT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CONTACT_OPEN      = 2'd0,
    CONTACT_CLOSED    = 2'd1,
    CONTACT_ERROR     = 2'd2,
    CONTACT_BAD_INDEX = 2'd3
  } contact_t;

  typedef enum logic [1:0] {
    FAULT_FUNCTIONAL = 2'd0,
    FAULT_WELDED     = 2'd1,
    FAULT_STUCK_OPEN = 2'd2,
    FAULT_BAD_INDEX  = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    REG_CONTACT_TYPE = 2'd0,
    REG_ACTIVE       = 2'd1,
    REG_SETTLE       = 2'd2,
    REG_ENABLE       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   contact_type_mask;
    logic [ACTIVE_W-1:0] active_relays;
    logic [SETTLE_W-1:0] settle_ticks;
    logic                monitor_enabled;
  } cfg_t;

  typedef struct packed {
    logic                   set_en;
    logic                   coil_on;
    logic                   tick_en;
    logic                   active;
    logic                   sample;
    logic                   type_nc;
    logic [TIMER_WIDTH-1:0] load_value;
  } lane_ctrl_t;

  typedef struct packed {
    logic coil;
    logic coil_nxt;
    logic feedback;
    logic fault;
    logic settled;
    logic type_nc;
  } lane_stat_t;

endpackage

// ===== rtl/rcfm_cfg.sv =====
// configuration register file behind the apb-style port
module rcfm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcfm_pkg::ADDR_W-1:0] paddr,
  input  logic [rcfm_pkg::DATA_W-1:0] pwdata,
  output logic [rcfm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rcfm_pkg::cfg_t              cfg
);
  import rcfm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CONTACT_TYPE: cfg_nxt.contact_type_mask = pwdata[TYPE_W-1:0];
        REG_ACTIVE:       cfg_nxt.active_relays     = pwdata[ACTIVE_W-1:0];
        REG_SETTLE:       cfg_nxt.settle_ticks      = pwdata[SETTLE_W-1:0];
        REG_ENABLE:       cfg_nxt.monitor_enabled   = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CONTACT_TYPE: prdata = DATA_W'(cfg_r.contact_type_mask);
      REG_ACTIVE:       prdata = DATA_W'(cfg_r.active_relays);
      REG_SETTLE:       prdata = DATA_W'(cfg_r.settle_ticks);
      REG_ENABLE:       prdata = DATA_W'(cfg_r.monitor_enabled);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.contact_type_mask <= '0;
      cfg_r.active_relays     <= ACTIVE_RESET;
      cfg_r.settle_ticks      <= SETTLE_RESET;
      cfg_r.monitor_enabled   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/rcfm_lane.sv =====
// one relay: coil, feedback and fault bits plus its settle countdown
module rcfm_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcfm_pkg::lane_ctrl_t ctrl,
  output rcfm_pkg::lane_stat_t stat
);
  import rcfm_pkg::*;

  logic                   coil_r, coil_nxt;
  logic                   feedback_r, feedback_nxt;
  logic                   fault_r, fault_nxt;
  logic [TIMER_WIDTH-1:0] count_r, count_nxt;

  always_comb begin
    coil_nxt     = coil_r;
    feedback_nxt = feedback_r;
    fault_nxt    = fault_r;
    count_nxt    = count_r;
    if (ctrl.set_en) begin
      coil_nxt  = ctrl.coil_on;
      count_nxt = ctrl.load_value;
    end else if (ctrl.tick_en) begin
      // inactive relays read back zero feedback and keep their count
      feedback_nxt = ctrl.active && ctrl.sample;
      fault_nxt    = coil_r ^ feedback_nxt ^ ctrl.type_nc;
      if (ctrl.active && (count_r != '0)) begin
        count_nxt = count_r - TIMER_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_r     <= 1'b0;
      feedback_r <= 1'b0;
      fault_r    <= 1'b0;
      count_r    <= '0;
    end else begin
      coil_r     <= coil_nxt;
      feedback_r <= feedback_nxt;
      fault_r    <= fault_nxt;
      count_r    <= count_nxt;
    end
  end

  assign stat.coil     = coil_r;
  assign stat.coil_nxt = coil_nxt;
  assign stat.feedback = feedback_r;
  assign stat.fault    = fault_r;
  assign stat.settled  = (count_r == '0);
  assign stat.type_nc  = ctrl.type_nc;

endmodule

// ===== rtl/rcfm_merge.sv =====
// picks the addressed lane, classifies it and registers the result beat
module rcfm_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  rcfm_pkg::op_t                       op,
  input  logic [rcfm_pkg::INDEX_W-1:0]        relay_sel,
  input  rcfm_pkg::lane_stat_t                stat [rcfm_pkg::RELAY_COUNT],
  output logic                                out_valid,
  output logic [rcfm_pkg::COIL_W-1:0]         out_coil_outputs,
  output logic [1:0]                          out_contact_status,
  output logic [1:0]                          out_fault_status
);
  import rcfm_pkg::*;

  logic [RELAY_COUNT-1:0] coil_vec;
  lane_stat_t             sel;
  logic                   idx_ok;
  contact_t               contact;
  fault_t                 fault;
  logic                   valid_r;
  logic [COIL_W-1:0]      coil_r;
  contact_t               contact_r;
  fault_t                 fault_r;

  always_comb begin
    for (int i = 0; i < RELAY_COUNT; i++) begin
      coil_vec[i] = stat[i].coil_nxt;
    end
  end

  assign idx_ok = (32'(relay_sel) < RELAY_COUNT);
  assign sel    = stat[relay_sel[LANE_W-1:0]];

  always_comb begin
    contact = CONTACT_OPEN;
    fault   = FAULT_FUNCTIONAL;
    if (op == OP_READ_CONTACT) begin
      priority if (!idx_ok)                  contact = CONTACT_BAD_INDEX;
      else if (sel.fault && sel.settled)     contact = CONTACT_ERROR;
      else if (sel.feedback)                 contact = CONTACT_CLOSED;
      else                                   contact = CONTACT_OPEN;
    end
    if (op == OP_READ_FAULT) begin
      // still settling reads as functional
      priority if (!idx_ok)                                 fault = FAULT_BAD_INDEX;
      else if (!sel.settled)                                fault = FAULT_FUNCTIONAL;
      else if (!sel.coil && (sel.feedback != sel.type_nc))  fault = FAULT_WELDED;
      else if (sel.coil && (sel.feedback == sel.type_nc))   fault = FAULT_STUCK_OPEN;
      else                                                  fault = FAULT_FUNCTIONAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coil_r    <= COIL_W'(coil_vec);
      contact_r <= contact;
      fault_r   <= fault;
    end
  end

  assign out_valid          = valid_r;
  assign out_coil_outputs   = coil_r;
  assign out_contact_status = contact_r;
  assign out_fault_status   = fault_r;

endmodule

// ===== rtl/relay_contact_fault_monitor_core.sv =====
// top level: config port, one lane per relay and the result merge stage
// latency: a result beat appears on the cycle after start is taken
// throughput: one item per cycle; busy stays low, lane state updates at the accept edge
// state updates and the addressed-lane readout share that same edge
// reset (rst_n low, synchronous) clears coils, feedback, faults and all countdowns
// and loads the register defaults; results are strobed once and cannot be stalled
module relay_contact_fault_monitor_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcfm_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcfm_pkg::DATA_W-1:0]  pwdata,
  output logic [rcfm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic [rcfm_pkg::INDEX_W-1:0] in_relay_sel,
  input  logic                         in_coil_on,
  input  logic [15:0]                  in_feedback_sample,
  output logic                         out_valid,
  output logic [rcfm_pkg::COIL_W-1:0]  out_coil_outputs,
  output logic [1:0]                   out_contact_status,
  output logic [1:0]                   out_fault_status
);
  import rcfm_pkg::*;

  cfg_t                   cfg;
  op_t                    op;
  logic                   accept;
  lane_ctrl_t             ctrl [RELAY_COUNT];
  lane_stat_t             stat [RELAY_COUNT];
  logic [RELAY_COUNT-1:0] coil_now;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_operation);

  rcfm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < RELAY_COUNT; i++) begin : g_lane
    always_comb begin
      ctrl[i].set_en     = accept && (op == OP_SET_COIL) &&
                           (in_relay_sel == INDEX_W'(i));
      ctrl[i].coil_on    = in_coil_on;
      ctrl[i].tick_en    = accept && (op == OP_TICK) && cfg.monitor_enabled;
      // an active count above the lane count simply enables every lane
      ctrl[i].active     = (32'(cfg.active_relays) > i);
      ctrl[i].sample     = in_feedback_sample[i];
      ctrl[i].type_nc    = cfg.contact_type_mask[i];
      ctrl[i].load_value = TIMER_WIDTH'(cfg.settle_ticks);
    end

    assign coil_now[i] = stat[i].coil;

    rcfm_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl[i]),
      .stat  (stat[i])
    );
  end

  rcfm_merge u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .op                 (op),
    .relay_sel          (in_relay_sel),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_coil_outputs   (out_coil_outputs),
    .out_contact_status (out_contact_status),
    .out_fault_status   (out_fault_status)
  );

  a_beat_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(accept)))
    else $error("result beat does not match accepted item");

  a_contact_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_contact_status != CONTACT_OPEN)) |->
      ($past(in_operation) == OP_READ_CONTACT))
    else $error("contact status set on a non contact read");

  a_fault_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault_status != FAULT_FUNCTIONAL)) |->
      ($past(in_operation) == OP_READ_FAULT))
    else $error("fault status set on a non fault read");

  a_bad_set_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_SET_COIL) && (32'(in_relay_sel) >= RELAY_COUNT)) |=>
      (coil_now == $past(coil_now)))
    else $error("out of range coil write changed a coil");

  a_reads_keep_coils: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((op == OP_READ_CONTACT) || (op == OP_READ_FAULT) || (op == OP_TICK))) |=>
      (coil_now == $past(coil_now)))
    else $error("coil changed on an item that does not drive coils");

endmodule

// ===== bench/relay_monitor_checker.sv =====
// checker for the relay monitor: predicts every result beat and compares it
module relay_monitor_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcfm_pkg::ADDR_W-1:0]    paddr,
  input  logic [rcfm_pkg::DATA_W-1:0]    pwdata,
  input  logic                           pready,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic [rcfm_pkg::INDEX_W-1:0]   in_relay_sel,
  input  logic                           in_coil_on,
  input  logic [15:0]                    in_feedback_sample,
  input  logic                           out_valid,
  input  logic [rcfm_pkg::COIL_W-1:0]    out_coil_outputs,
  input  logic [1:0]                     out_contact_status,
  input  logic [1:0]                     out_fault_status,
  output int                             fail_count,
  output int                             results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcfm_pkg::*;

  typedef struct packed {
    logic [COIL_W-1:0] coil;
    contact_t          contact;
    fault_t            fault;
  } relay_beat_t;

  relay_beat_t owed_beats[$];

  // shadow of the block state
  logic [RELAY_COUNT-1:0] coil_q;
  logic [RELAY_COUNT-1:0] feedback_q;
  logic [RELAY_COUNT-1:0] fault_q;
  logic [TIMER_WIDTH-1:0] countdown [RELAY_COUNT];

  // shadow of the registers
  logic [TYPE_W-1:0]   type_mask;
  logic [ACTIVE_W-1:0] active_cnt;
  logic [SETTLE_W-1:0] settle_load;
  logic                enabled;

  function automatic relay_beat_t step_relays(op_t op, logic [INDEX_W-1:0] idx,
                                              logic coil_on, logic [15:0] sample);
    relay_beat_t r;
    int lanes;
    logic in_range;
    logic c, f, t;
    in_range  = idx < RELAY_COUNT;
    r.contact = CONTACT_OPEN;
    r.fault   = FAULT_FUNCTIONAL;
    case (op)
      OP_SET_COIL: begin
        if (in_range) begin
          countdown[idx] = TIMER_WIDTH'(settle_load);
          coil_q[idx]    = coil_on;
        end
      end
      OP_TICK: begin
        if (enabled) begin
          lanes = (active_cnt > RELAY_COUNT) ? RELAY_COUNT : int'(active_cnt);
          feedback_q = '0;
          for (int i = 0; i < lanes; i++) begin
            feedback_q[i] = sample[i];
            if (countdown[i] != 0) countdown[i] = countdown[i] - 1'b1;
          end
          fault_q = coil_q ^ feedback_q ^ type_mask[RELAY_COUNT-1:0];
        end
      end
      OP_READ_CONTACT: begin
        if (!in_range) r.contact = CONTACT_BAD_INDEX;
        else if (fault_q[idx] && countdown[idx] == 0) r.contact = CONTACT_ERROR;
        else if (feedback_q[idx]) r.contact = CONTACT_CLOSED;
        else r.contact = CONTACT_OPEN;
      end
      default: begin
        if (!in_range) begin
          r.fault = FAULT_BAD_INDEX;
        end else if (countdown[idx] == 0) begin
          c = coil_q[idx];
          f = feedback_q[idx];
          t = type_mask[idx];
          if (!c && f != t) r.fault = FAULT_WELDED;
          else if (c && f == t) r.fault = FAULT_STUCK_OPEN;
        end
      end
    endcase
    r.coil = COIL_W'(coil_q);
    return r;
  endfunction

  always @(posedge clk) begin
    relay_beat_t want;
    if (!rst_n) begin
      coil_q      = '0;
      feedback_q  = '0;
      fault_q     = '0;
      for (int i = 0; i < RELAY_COUNT; i++) countdown[i] = '0;
      type_mask   = '0;
      active_cnt  = ACTIVE_RESET;
      settle_load = SETTLE_RESET;
      enabled     = 1'b1;
      fail_count  = 0;
      owed_beats.delete();
    end else begin
      // result first: a beat leaving and an item entering at one edge keep their order
      if (out_valid) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with no item outstanding");
          fail_count++;
        end else begin
          want = owed_beats.pop_front();
          if (out_coil_outputs !== want.coil) begin
            $error("coil_outputs: expected %h, got %h", want.coil, out_coil_outputs);
            fail_count++;
          end
          if (out_contact_status !== want.contact) begin
            $error("contact_status: expected %0d, got %0d", want.contact,
                   out_contact_status);
            fail_count++;
          end
          if (out_fault_status !== want.fault) begin
            $error("fault_status: expected %0d, got %0d", want.fault, out_fault_status);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        owed_beats.push_back(step_relays(op_t'(in_operation), in_relay_sel,
                                         in_coil_on, in_feedback_sample));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CONTACT_TYPE: type_mask   = pwdata[TYPE_W-1:0];
          REG_ACTIVE:       active_cnt  = pwdata[ACTIVE_W-1:0];
          REG_SETTLE:       settle_load = pwdata[SETTLE_W-1:0];
          REG_ENABLE:       enabled     = pwdata[0];
          default: ;
        endcase
      end
    end
    results_owed = owed_beats.size();
  end

endmodule

// ===== bench/relay_contact_fault_monitor_core_test.sv =====
// testbench top for the relay monitor: clock, reset, stimulus and verdict
module relay_contact_fault_monitor_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rcfm_pkg::*;

  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 150;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_operation = '0;
  logic [INDEX_W-1:0]  in_relay_sel = '0;
  logic                in_coil_on = 1'b0;
  logic [15:0]         in_feedback_sample = '0;
  logic                out_valid;
  logic [COIL_W-1:0]   out_coil_outputs;
  logic [1:0]          out_contact_status;
  logic [1:0]          out_fault_status;
  int                  fail_count;
  int                  results_owed;
  logic [TYPE_W-1:0]   phase_type;

  relay_contact_fault_monitor_core uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_operation(in_operation), .in_relay_sel(in_relay_sel),
    .in_coil_on(in_coil_on), .in_feedback_sample(in_feedback_sample),
    .out_valid(out_valid), .out_coil_outputs(out_coil_outputs),
    .out_contact_status(out_contact_status), .out_fault_status(out_fault_status)
  );

  relay_monitor_checker chk (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .start(start), .busy(busy),
    .in_operation(in_operation), .in_relay_sel(in_relay_sel),
    .in_coil_on(in_coil_on), .in_feedback_sample(in_feedback_sample),
    .out_valid(out_valid), .out_coil_outputs(out_coil_outputs),
    .out_contact_status(out_contact_status), .out_fault_status(out_fault_status),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  always #5 clk = ~clk;

  task automatic reg_write(reg_idx_t r, logic [DATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // start stays high after the beat; the caller decides whether a gap follows
  task automatic send_item(op_t op, logic [INDEX_W-1:0] idx, logic coil,
                           logic [15:0] fb);
    start              <= 1'b1;
    in_operation       <= op;
    in_relay_sel       <= idx;
    in_coil_on         <= coil;
    in_feedback_sample <= fb;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  // wait until every owed result is back, then let the pipe go quiet
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(logic [TYPE_W-1:0] tm, logic [ACTIVE_W-1:0] act,
                             logic [SETTLE_W-1:0] st, logic en);
    phase_type = tm;
    reg_write(REG_CONTACT_TYPE, DATA_W'(tm));
    reg_write(REG_ACTIVE, DATA_W'(act));
    reg_write(REG_SETTLE, DATA_W'(st));
    reg_write(REG_ENABLE, DATA_W'(en));
  endtask

  task automatic random_item();
    op_t op;
    logic [INDEX_W-1:0] idx;
    logic [15:0] fb;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) op = OP_SET_COIL;
    else if (pick < 6) op = OP_TICK;
    else if (pick < 8) op = OP_READ_CONTACT;
    else op = OP_READ_FAULT;
    idx = ($urandom_range(0, 7) == 0) ? INDEX_W'($urandom_range(16, 31))
                                      : INDEX_W'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      3:       fb = phase_type;
      4:       fb = ~phase_type;
      5:       fb = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: fb = 16'($urandom());
    endcase
    send_item(op, idx, 1'($urandom_range(0, 1)), fb);
  endtask

  initial begin
    logic [TYPE_W-1:0]   tm;
    logic [ACTIVE_W-1:0] act;
    logic [SETTLE_W-1:0] st;
    logic                en;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: long settle time, all relays scanned
    send_item(OP_READ_FAULT, 0, 1'b0, 16'h0000);
    send_item(OP_READ_CONTACT, 0, 1'b0, 16'h0000);
    send_item(OP_SET_COIL, 0, 1'b1, 16'h0000);
    send_item(OP_READ_FAULT, 0, 1'b0, 16'h0000);   // still settling
    send_item(OP_SET_COIL, 16, 1'b1, 16'h0000);    // out of range, ignored
    send_item(OP_SET_COIL, 31, 1'b0, 16'hffff);
    send_item(OP_READ_CONTACT, 31, 1'b1, 16'h0000);
    send_item(OP_READ_FAULT, 16, 1'b0, 16'h0000);
    send_item(OP_TICK, 5, 1'b1, 16'hffff);
    send_item(OP_TICK, 0, 1'b0, 16'h0000);
    send_item(OP_READ_CONTACT, 0, 1'b0, 16'h0000);
    drain();

    // short settle, half the relays scanned, mixed contact types
    load_config(16'h00f0, 5'd8, 16'd1, 1'b1);
    send_item(OP_SET_COIL, 0, 1'b1, 16'h0000);
    send_item(OP_SET_COIL, 1, 1'b1, 16'h0000);
    send_item(OP_SET_COIL, 4, 1'b1, 16'h0000);
    send_item(OP_SET_COIL, 9, 1'b1, 16'h0000);
    send_item(OP_TICK, 0, 1'b0, 16'h0201);         // relay 9 lies above the active count
    send_item(OP_READ_CONTACT, 0, 1'b0, 16'h0000);
    send_item(OP_READ_CONTACT, 1, 1'b0, 16'h0000);
    send_item(OP_READ_FAULT, 1, 1'b0, 16'h0000);
    send_item(OP_READ_FAULT, 2, 1'b0, 16'h0000);
    send_item(OP_READ_FAULT, 4, 1'b0, 16'h0000);
    send_item(OP_READ_FAULT, 5, 1'b0, 16'h0000);
    send_item(OP_READ_CONTACT, 9, 1'b0, 16'h0000);
    send_item(OP_READ_FAULT, 9, 1'b0, 16'h0000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      tm  = 16'($urandom());
      act = ($urandom_range(0, 2) == 0) ? 5'($urandom()) : 5'd16;
      st  = 16'($urandom_range(0, 10));
      en  = ($urandom_range(0, 5) != 0);
      case (p)
        0: begin tm = 16'h0000; act = 5'd16; st = 16'd0; en = 1'b1; end
        1: begin tm = 16'hffff; act = 5'd16; st = 16'd3; en = 1'b1; end
        2: begin act = 5'd0;  st = 16'd2; en = 1'b1; end
        3: begin act = 5'd31; st = 16'd1; en = 1'b1; end
        4: begin act = 5'($urandom_range(1, 15)); st = 16'd5; en = 1'b1; end
        5: begin act = 5'd16; st = 16'hffff; en = 1'b1; end
        6: begin st = 16'd4; en = 1'b0; end
        7: begin act = 5'd17; en = 1'b1; end
        default: ;
      endcase
      load_config(tm, act, st, en);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_item();
        // no gaps over the closing stretch of the run
        if (!(p == PHASES - 1 && k >= PHASE_ITEMS / 2) && $urandom_range(0, 3) == 0)
          hold_off();
      end
      drain();
    end

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rcfm_pkg.sv
rtl/rcfm_cfg.sv
rtl/rcfm_lane.sv
rtl/rcfm_merge.sv
rtl/relay_contact_fault_monitor_core.sv
bench/relay_monitor_checker.sv
bench/relay_contact_fault_monitor_core_test.sv
